// ===== sv/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

  localparam int OP_W       = 3;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 5;
  localparam int CNT_OUT_W  = 5;
  localparam int CAPACITY_D = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

endpackage

// ===== sv/positional_list_engine.sv =====
`timescale 1ns / 1ps
// One request at a time; the next start is taken in the strobe cycle. Failed or
//   unused requests strobe the result without leaving idle. Every step of a
//   shift or scan is a registered read of the entry store, then a write or a
//   compare.
// Reset clears the count and the sequencer; entry contents stay undefined until written.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = CAPACITY_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             in_op,
  input  logic signed [VAL_W-1:0]     in_value_in,
  input  logic [POS_W-1:0]            in_position,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic signed [VAL_W-1:0]     out_value_out,
  output logic [CNT_OUT_W-1:0]        out_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_MV,
    ST_INS_NEW,
    ST_DEL_RD,
    ST_DEL_GET,
    ST_SH_RD,
    ST_SH_MV,
    ST_DEL_END,
    ST_SR_RD,
    ST_SR_CMP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [VAL_W-1:0]         value_r, value_nxt;
  logic [VAL_W-1:0]         removed_r, removed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0]         out_value_r, out_value_nxt;

  logic [VAL_W-1:0]         mem [CAPACITY];
  logic [VAL_W-1:0]         rdata_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic [VAL_W-1:0]         mem_wdata;

  logic [CMPW-1:0]          cnt_ext;
  logic [CMPW-1:0]          tgt;
  logic [CW-1:0]            idx_dec;
  logic [CW-1:0]            idx_inc;
  logic [CW:0]              idx_inc2;

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_value_r;
  assign out_count     = CNT_OUT_W'(CMPW'(count_r));

  assign cnt_ext  = CMPW'(count_r);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_inc2 = (CW + 1)'(idx_r) + (CW + 1)'(2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    removed_nxt   = removed_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_raddr     = idx_r[AW-1:0];
    mem_wdata     = rdata_r;
    tgt           = CMPW'(in_position);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          value_nxt     = in_value_in;
          out_ok_nxt    = 1'b0;
          out_value_nxt = '0;
          unique case (op_t'(in_op))
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
              if (op_t'(in_op) == OP_INS_FRONT) begin
                tgt = '0;
              end else if (op_t'(in_op) == OP_INS_END) begin
                tgt = cnt_ext;
              end
              if (cnt_ext >= CAP_C || tgt > cnt_ext) begin
                out_valid_nxt = 1'b1;
              end else begin
                pos_nxt   = tgt[CW-1:0];
                idx_nxt   = count_r;
                state_nxt = (cnt_ext > tgt) ? ST_INS_RD : ST_INS_NEW;
              end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
              if (op_t'(in_op) == OP_DEL_FRONT) begin
                tgt = '0;
              end else if (op_t'(in_op) == OP_DEL_END) begin
                tgt = cnt_ext - CMPW'(1);
              end
              if (count_r == '0 || tgt >= cnt_ext) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = tgt[CW-1:0];
                state_nxt = ST_DEL_RD;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_SR_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // Shift up from the tail, one entry per read/write pair
      ST_INS_RD: begin
        mem_raddr = idx_dec[AW-1:0];
        state_nxt = ST_INS_MV;
      end
      ST_INS_MV: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rdata_r;
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec == pos_r) ? ST_INS_NEW : ST_INS_RD;
      end
      ST_INS_NEW: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_r[AW-1:0];
        mem_wdata     = value_r;
        count_nxt     = count_r + CW'(1);
        out_ok_nxt    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DEL_RD: begin
        mem_raddr = idx_r[AW-1:0];
        state_nxt = ST_DEL_GET;
      end
      ST_DEL_GET: begin
        removed_nxt = rdata_r;
        state_nxt   = (idx_inc < count_r) ? ST_SH_RD : ST_DEL_END;
      end
      // Close the gap, pulling each later entry down by one
      ST_SH_RD: begin
        mem_raddr = idx_inc[AW-1:0];
        state_nxt = ST_SH_MV;
      end
      ST_SH_MV: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rdata_r;
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc2 < (CW + 1)'(count_r)) ? ST_SH_RD : ST_DEL_END;
      end
      ST_DEL_END: begin
        count_nxt     = count_r - CW'(1);
        out_ok_nxt    = 1'b1;
        out_value_nxt = removed_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SR_RD: begin
        mem_raddr = idx_r[AW-1:0];
        state_nxt = ST_SR_CMP;
      end
      ST_SR_CMP: begin
        if (rdata_r == value_r) begin
          out_ok_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (idx_inc >= count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SR_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    value_r     <= value_nxt;
    removed_r   <= removed_nxt;
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

// ===== tb/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 412;
  localparam int NUM_ROWS = 21;

  typedef struct packed {
    logic                 ok;
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [VAL_W-1:0]     value;
    logic [POS_W-1:0]     pos;
    logic                 has_exp;
    logic                 ok;
    logic [VAL_W-1:0]     value_out;
    logic [CNT_OUT_W-1:0] count;
  } request_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_op = '0;
  logic signed [VAL_W-1:0] in_value_in = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_ok;
  logic signed [VAL_W-1:0] out_value_out;
  logic [CNT_OUT_W-1:0]    out_count;

  // typed expectation for the request currently on the input ports
  logic         drv_has_exp = 1'b0;
  list_result_t drv_exp = '0;

  // shadow copy of the list, front at index 0
  logic [VAL_W-1:0] list_store [CAPACITY_D];
  int               held = 0;

  list_result_t expected_results [$];
  int mismatches = 0;
  int taken = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int full_refusals = 0;
  int empty_failures = 0;
  int search_hits = 0;

  request_row_t directed_rows [NUM_ROWS] = '{
    '{OP_SEARCH,    32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_FRONT, 32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_END,   32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_POS,   32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0, 5'd0},
    '{OP_INS_POS,   32'h0000_0005, 5'd1,  1'b1, 1'b0, 32'h0, 5'd0},
    '{OP_INS_POS,   32'h8000_0000, 5'd0,  1'b1, 1'b1, 32'h0, 5'd1},
    '{OP_INS_END,   32'h7FFF_FFFF, 5'd0,  1'b1, 1'b1, 32'h0, 5'd2},
    '{OP_INS_FRONT, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b1, 32'h0, 5'd3},
    '{OP_INS_POS,   32'h0000_0000, 5'd3,  1'b1, 1'b1, 32'h0, 5'd4},
    '{OP_SEARCH,    32'h8000_0000, 5'd0,  1'b1, 1'b1, 32'h0, 5'd4},
    '{OP_SEARCH,    32'h0000_0005, 5'd0,  1'b1, 1'b0, 32'h0, 5'd4},
    '{OP_DEL_POS,   32'h0000_0000, 5'd4,  1'b1, 1'b0, 32'h0, 5'd4},
    '{OP_DEL_POS,   32'h0000_0000, 5'd31, 1'b1, 1'b0, 32'h0, 5'd4},
    '{OP_INS_POS,   32'h1234_5678, 5'd31, 1'b1, 1'b0, 32'h0, 5'd4},
    '{OP_UNUSED,    32'hFFFF_FFFF, 5'd31, 1'b1, 1'b0, 32'h0, 5'd4},
    '{OP_INS_POS,   32'h0000_A5A5, 5'd2,  1'b0, 1'b0, 32'h0, 5'd0},
    '{OP_SEARCH,    32'h0000_A5A5, 5'd0,  1'b0, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_POS,   32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_END,   32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0, 5'd0},
    '{OP_DEL_FRONT, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0, 5'd0},
    '{OP_SEARCH,    32'hFFFF_FFFF, 5'd0,  1'b0, 1'b0, 32'h0, 5'd0}
  };

  int idle_pct [4] = '{0, 70, 6, 0};

  positional_list_engine uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value_in  (in_value_in),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_value_out(out_value_out),
    .out_count    (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int at;
    int i;
    r = '0;
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        if (op == OP_INS_FRONT) at = 0;
        else if (op == OP_INS_END) at = held;
        else at = int'(pos);
        if (held < CAPACITY_D && at <= held) begin
          for (i = held; i > at; i--) list_store[i] = list_store[i-1];
          list_store[at] = v;
          held++;
          r.ok = 1'b1;
        end else if (held == CAPACITY_D) begin
          full_refusals++;
        end
      end
      OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
        if (op == OP_DEL_FRONT) at = 0;
        else if (op == OP_DEL_END) at = held - 1;
        else at = int'(pos);
        if (held > 0 && at < held) begin
          r.value = list_store[at];
          for (i = at; i + 1 < held; i++) list_store[i] = list_store[i+1];
          held--;
          r.ok = 1'b1;
        end else if (held == 0) begin
          empty_failures++;
        end
      end
      OP_SEARCH: begin
        if (held == 0) empty_failures++;
        for (i = 0; i < held; i++)
          if (list_store[i] == v) r.ok = 1'b1;
        if (r.ok) search_hits++;
      end
      default: ;
    endcase
    r.count = held[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    if (mismatches < 50)
      $display("mismatch: %s at result %0d, expected %h, got %h",
               what, results_seen, want, got);
    mismatches++;
  endtask

  // check results first, then record a transfer on the input side
  always @(posedge clk) begin
    list_result_t want;
    list_result_t predicted;
    logic         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, out_value_out);
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", VAL_W'(want.ok), VAL_W'(out_ok));
          if (out_value_out !== want.value)
            report_mismatch("value_out", want.value, out_value_out);
          if (out_count !== want.count)
            report_mismatch("count", VAL_W'(want.count), VAL_W'(out_count));
        end
        results_seen++;
      end
      if (start && !busy) begin
        moved = 1'b1;
        predicted = apply_list_op(in_op, in_value_in, in_position);
        expected_results.push_back(drv_has_exp ? drv_exp : predicted);
        taken++;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // entered just after a falling edge, returns just after the falling edge that
  // follows the transfer, with start still high
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v,
                              input logic [POS_W-1:0] pos, input logic has_exp,
                              input list_result_t exp);
    start       <= 1'b1;
    in_op       <= op;
    in_value_in <= v;
    in_position <= pos;
    drv_has_exp <= has_exp;
    drv_exp     <= exp;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request(input int ins_w);
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] pos;
    int r;
    r = $urandom_range(99);
    if (r < ins_w) begin
      case ($urandom_range(2))
        0: op = OP_INS_FRONT;
        1: op = OP_INS_END;
        default: op = OP_INS_POS;
      endcase
    end else if (r < 95) begin
      case ($urandom_range(3))
        0: op = OP_DEL_FRONT;
        1: op = OP_DEL_END;
        2: op = OP_DEL_POS;
        default: op = OP_SEARCH;
      endcase
    end else begin
      op = OP_W'($urandom_range(7));
    end
    // small pool so that duplicates and search hits are common
    r = $urandom_range(99);
    if (r < 40) v = $urandom_range(7) - 4;
    else if (r < 50) begin
      case ($urandom_range(3))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else v = $urandom;
    if (op == OP_SEARCH && held > 0 && $urandom_range(1))
      v = list_store[$urandom_range(held - 1)];
    r = $urandom_range(99);
    if (r < 75) pos = POS_W'($urandom_range(held));
    else if (r < 90) pos = POS_W'($urandom_range(CAPACITY_D));
    else pos = POS_W'($urandom_range(31));
    send_request(op, v, pos, 1'b0, '0);
  endtask

  initial begin
    list_result_t row_exp;
    int ins_w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row_exp = '{directed_rows[i].ok, directed_rows[i].value_out, directed_rows[i].count};
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                   directed_rows[i].has_exp, row_exp);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      ins_w = 45;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // switch between growing, shrinking and balanced stretches
        if ($urandom_range(29) == 0) begin
          case ($urandom_range(2))
            0: ins_w = 75;
            1: ins_w = 15;
            default: ins_w = 45;
          endcase
        end
        sender_gap(idle_pct[phase]);
        random_request(ins_w);
      end
      // hold off until every outstanding result is back
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d directed) and %0d results over four idling phases.",
             taken, NUM_ROWS, results_seen);
    $display("Full-list insert refusals %0d, empty-list failures %0d, search hits %0d.",
             full_refusals, empty_failures, search_hits);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ple_pkg.sv
sv/positional_list_engine.sv
tb/positional_list_engine_tb.sv
